### hdl/csp_pkg.sv
// Shared types and constants for the circulant shortest-path router.
`timescale 1ns / 1ps
`default_nettype none
package csp_pkg;

   localparam int ID_W       = 10;
   localparam int PORT_W     = 3;
   localparam int MASK_W     = 4;
   localparam int CNT_W      = 11;
   localparam int STEP_W     = 10;
   localparam int DIST_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int SMALL_RING = 16;

   localparam logic [CSR_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_LONG_STEP  = 2'd1;

   localparam logic [CNT_W-1:0]  RESET_NODE_COUNT = 11'd16;
   localparam logic [STEP_W-1:0] RESET_LONG_STEP  = 10'd4;

   localparam logic [PORT_W-1:0] PORT_LOCAL = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLEAR,
      ST_MOD,
      ST_SEED,
      ST_POP,
      ST_NB_RD,
      ST_NB_WR,
      ST_LK_RD,
      ST_LK_ACC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_init;
      logic clr_step;
      logic mod_init;
      logic mod_step;
      logic seed;
      logic pop_rd;
      logic nb_rd;
      logic nb_wr;
      logic lk_init;
      logic lk_rd;
      logic lk_acc;
      logic set_ready;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic id_err;
      logic is_local;
      logic table_ready;
      logic clr_last;
      logic mod_last;
      logic q_empty;
      logic k_last;
   } status_type;

endpackage
`default_nettype wire

### hdl/csp_ctrl.sv
// Controller state machine of the circulant shortest-path router.
`timescale 1ns / 1ps
`default_nettype none
module csp_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  csp_pkg::status_type      status,
   output csp_pkg::cmd_type         cmd,
   output logic                     busy
);

   csp_pkg::state_type state_ff;
   csp_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csp_pkg::ST_IDLE: begin
            if (start) state_in = csp_pkg::ST_CHECK;
         end
         csp_pkg::ST_CHECK: begin
            if (status.id_err || status.is_local) state_in = csp_pkg::ST_RESP;
            else if (status.table_ready)          state_in = csp_pkg::ST_LK_RD;
            else                                  state_in = csp_pkg::ST_CLEAR;
         end
         csp_pkg::ST_CLEAR: begin
            if (status.clr_last) state_in = csp_pkg::ST_MOD;
         end
         csp_pkg::ST_MOD: begin
            if (status.mod_last) state_in = csp_pkg::ST_SEED;
         end
         csp_pkg::ST_SEED: begin
            state_in = csp_pkg::ST_POP;
         end
         csp_pkg::ST_POP: begin
            if (status.q_empty) state_in = csp_pkg::ST_LK_RD;
            else                state_in = csp_pkg::ST_NB_RD;
         end
         csp_pkg::ST_NB_RD: begin
            state_in = csp_pkg::ST_NB_WR;
         end
         csp_pkg::ST_NB_WR: begin
            if (status.k_last) state_in = csp_pkg::ST_POP;
            else               state_in = csp_pkg::ST_NB_RD;
         end
         csp_pkg::ST_LK_RD: begin
            state_in = csp_pkg::ST_LK_ACC;
         end
         csp_pkg::ST_LK_ACC: begin
            if (status.k_last) state_in = csp_pkg::ST_RESP;
            else               state_in = csp_pkg::ST_LK_RD;
         end
         csp_pkg::ST_RESP: begin
            state_in = csp_pkg::ST_IDLE;
         end
         default: begin
            state_in = csp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         csp_pkg::ST_IDLE: begin
            busy         = 1'b0;
            cmd.load_req = start;
         end
         csp_pkg::ST_CHECK: begin
            // The chord remainder is kept while the table stays valid.
            cmd.clr_init = 1'b1;
            cmd.mod_init = !status.table_ready;
            cmd.lk_init  = 1'b1;
         end
         csp_pkg::ST_CLEAR:  cmd.clr_step = 1'b1;
         csp_pkg::ST_MOD:    cmd.mod_step = 1'b1;
         csp_pkg::ST_SEED:   cmd.seed     = 1'b1;
         csp_pkg::ST_POP: begin
            if (status.q_empty) begin
               cmd.set_ready = 1'b1;
               cmd.lk_init   = 1'b1;
            end else begin
               cmd.pop_rd = 1'b1;
            end
         end
         csp_pkg::ST_NB_RD:  cmd.nb_rd    = 1'b1;
         csp_pkg::ST_NB_WR:  cmd.nb_wr    = 1'b1;
         csp_pkg::ST_LK_RD:  cmd.lk_rd    = 1'b1;
         csp_pkg::ST_LK_ACC: cmd.lk_acc   = 1'b1;
         csp_pkg::ST_RESP:   cmd.rsp_load = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

### hdl/csp_datapath.sv
// Datapath of the circulant shortest-path router: registers, distance table and BFS queue.
`timescale 1ns / 1ps
`default_nettype none
module csp_datapath #(
   parameter int MAX_NODES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  csp_pkg::cmd_type                       cmd,
   output csp_pkg::status_type                    status,
   input  wire logic [csp_pkg::ID_W-1:0]          req_current_node,
   input  wire logic [csp_pkg::ID_W-1:0]          req_destination_node,
   input  wire logic [csp_pkg::PORT_W-1:0]        req_arrival_port,
   input  wire logic                              csr_write,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [csp_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                   rsp_valid,
   output logic [csp_pkg::MASK_W-1:0]             rsp_port_mask,
   output logic                                   rsp_deliver_local,
   output logic                                   rsp_id_error
);

   localparam int AW = $clog2(MAX_NODES);
   localparam int NW = AW + 1;
   localparam int CW = (NW > csp_pkg::CNT_W) ? NW : csp_pkg::CNT_W;
   localparam int QW = AW + csp_pkg::DIST_W;
   localparam int DW = csp_pkg::DIST_W;

   // Mod-n difference of two values that are both below n.
   function automatic logic [NW-1:0] mod_sub(input logic [NW-1:0] a,
                                             input logic [NW-1:0] b,
                                             input logic [NW-1:0] n);
      mod_sub = (a >= b) ? (a - b) : (a + n - b);
   endfunction

   // Neighbor of x over link k: +1, +s, -1, -s.
   function automatic logic [NW-1:0] nbr(input logic [NW-1:0] x,
                                         input logic [1:0]    k,
                                         input logic [NW-1:0] n,
                                         input logic [NW-1:0] s);
      logic [NW-1:0] t;
      t = '0;
      case (k)
         2'd0: begin
            t = x + NW'(1);
            if (t >= n) t = t - n;
         end
         2'd1: begin
            t = x + s;
            if (t >= n) t = t - n;
         end
         2'd2: t = mod_sub(x, NW'(1), n);
         2'd3: t = mod_sub(x, s, n);
         default: t = x;
      endcase
      nbr = t;
   endfunction

   function automatic logic [2:0] pop4(input logic [3:0] m);
      pop4 = {2'b00, m[0]} + {2'b00, m[1]} + {2'b00, m[2]} + {2'b00, m[3]};
   endfunction

   // Configuration and control registers.
   logic [csp_pkg::CNT_W-1:0]  node_count_ff;
   logic [csp_pkg::STEP_W-1:0] long_step_ff;
   logic                       table_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= csp_pkg::RESET_NODE_COUNT;
         long_step_ff   <= csp_pkg::RESET_LONG_STEP;
         table_ready_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == csp_pkg::CFG_NODE_COUNT) begin
            node_count_ff  <= csr_data;
            table_ready_ff <= 1'b0;
         end else if (csr_write && csr_index == csp_pkg::CFG_LONG_STEP) begin
            long_step_ff   <= csr_data[csp_pkg::STEP_W-1:0];
            table_ready_ff <= 1'b0;
         end else if (cmd.set_ready) begin
            table_ready_ff <= 1'b1;
         end
      end
   end

   // Effective node count, clipped to the table depth.
   logic [CW-1:0] n_cw;
   logic [NW-1:0] n_eff;
   always_comb begin
      n_cw  = (CW'(node_count_ff) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_ff);
      n_eff = n_cw[NW-1:0];
   end

   // Request capture.
   logic [csp_pkg::ID_W-1:0]   cur_ff;
   logic [csp_pkg::ID_W-1:0]   dst_ff;
   logic [csp_pkg::PORT_W-1:0] arr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cur_ff <= req_current_node;
         dst_ff <= req_destination_node;
         arr_ff <= req_arrival_port;
      end
   end

   logic          id_err;
   logic [NW-1:0] cur_n;
   logic [NW-1:0] dst_n;
   always_comb begin
      id_err = (CW'(cur_ff) >= n_cw) || (CW'(dst_ff) >= n_cw);
      cur_n  = NW'(cur_ff);
      dst_n  = NW'(dst_ff);
   end

   // Counters and the serial remainder unit for s mod n.
   logic [NW-1:0] clr_cnt_ff;
   logic [NW-1:0] rem_ff;
   logic [3:0]    bit_ff;
   logic [NW-1:0] head_ff;
   logic [NW-1:0] tail_ff;
   logic [1:0]    k_ff;
   logic [NW-1:0] rem_sh;
   logic [NW-1:0] rem_in;

   always_comb begin
      rem_sh = {rem_ff[AW-1:0], long_step_ff[bit_ff]};
      rem_in = (rem_sh >= n_eff) ? (rem_sh - n_eff) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_init)      clr_cnt_ff <= '0;
      else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + NW'(1);

      if (cmd.mod_init) begin
         rem_ff <= '0;
         bit_ff <= 4'(csp_pkg::STEP_W - 1);
      end else if (cmd.mod_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - 4'd1;
      end

      if (cmd.seed)        head_ff <= '0;
      else if (cmd.pop_rd) head_ff <= head_ff + NW'(1);

      if (cmd.pop_rd || cmd.lk_init)     k_ff <= 2'd0;
      else if (cmd.nb_wr || cmd.lk_acc) k_ff <= k_ff + 2'd1;
   end

   // Memories: visited marks, BFS queue of {distance, node}, hop distance table.
   logic          seen_mem [MAX_NODES];
   logic [QW-1:0] queue_mem [MAX_NODES];
   logic [DW-1:0] dist_mem [MAX_NODES];
   logic          seen_rd_ff;
   logic [QW-1:0] q_rd_ff;
   logic [DW-1:0] dist_rd_ff;

   logic [NW-1:0] u_n;
   logic [DW-1:0] du;
   logic [DW-1:0] du_next;
   logic [NW-1:0] v_n;
   logic [NW-1:0] lk_next;
   logic [NW-1:0] lk_off;
   logic          bfs_add;

   always_comb begin
      u_n     = {1'b0, q_rd_ff[AW-1:0]};
      du      = q_rd_ff[QW-1:AW];
      du_next = du + DW'(1);
      v_n     = nbr(u_n, k_ff, n_eff, rem_ff);
      lk_next = nbr(cur_n, k_ff, n_eff, rem_ff);
      lk_off  = mod_sub(dst_n, lk_next, n_eff);
      bfs_add = cmd.nb_wr && !seen_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step)  seen_mem[clr_cnt_ff[AW-1:0]] <= 1'b0;
      else if (cmd.seed) seen_mem[0] <= 1'b1;
      else if (bfs_add)  seen_mem[v_n[AW-1:0]] <= 1'b1;
      if (cmd.nb_rd) seen_rd_ff <= seen_mem[v_n[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.seed)     queue_mem[0] <= '0;
      else if (bfs_add) queue_mem[tail_ff[AW-1:0]] <= {du_next, v_n[AW-1:0]};
      if (cmd.pop_rd) q_rd_ff <= queue_mem[head_ff[AW-1:0]];
   end

   // The queue tail advances with every newly visited node.
   always_ff @(posedge clock) begin
      if (cmd.seed)     tail_ff <= NW'(1);
      else if (bfs_add) tail_ff <= tail_ff + NW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.seed)     dist_mem[0] <= '0;
      else if (bfs_add) dist_mem[v_n[AW-1:0]] <= du_next;
      if (cmd.lk_rd) dist_rd_ff <= dist_mem[lk_off[AW-1:0]];
   end

   // Best-distance accumulation over the four links.
   logic [DW:0]               best_ff;
   logic [csp_pkg::MASK_W-1:0] mask_ff;
   logic [DW:0]               d_k;

   always_comb begin
      d_k = {1'b0, dist_rd_ff} + (DW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.lk_init) begin
         best_ff <= '1;
         mask_ff <= '0;
      end else if (cmd.lk_acc) begin
         if (d_k < best_ff) begin
            best_ff <= d_k;
            mask_ff <= 4'(1) << k_ff;
         end else if (d_k == best_ff) begin
            mask_ff <= mask_ff | (4'(1) << k_ff);
         end
      end
   end

   // Port pruning: long links first, then for large rings backtrack removal,
   // ring direction and a fixed priority.
   logic       big_ring;
   logic       pos_dir;
   logic [3:0] m_a;
   logic [3:0] m_b;
   logic [3:0] m_c;
   logic [3:0] m_d;

   always_comb begin
      big_ring = n_cw > CW'(csp_pkg::SMALL_RING);
      pos_dir  = mod_sub(dst_n, cur_n, n_eff) <= mod_sub(cur_n, dst_n, n_eff);

      m_a = mask_ff;
      if ((m_a & 4'b1010) != 4'b0000) m_a = m_a & 4'b1010;

      m_b = m_a;
      if (big_ring && pop4(m_b) > 3'd1 && arr_ff < csp_pkg::PORT_LOCAL) begin
         m_b[arr_ff[1:0]] = 1'b0;
      end

      m_c = m_b;
      if (big_ring && pop4(m_c) > 3'd1 && (m_c[1:0] != 2'b00) && (m_c[3:2] != 2'b00)) begin
         m_c = m_c & (pos_dir ? 4'b0011 : 4'b1100);
      end

      m_d = m_c;
      if (big_ring && pop4(m_c) > 3'd1) begin
         if (pos_dir) begin
            if (m_c[1])      m_d = 4'b0010;
            else if (m_c[0]) m_d = 4'b0001;
            else if (m_c[3]) m_d = 4'b1000;
            else             m_d = 4'b0100;
         end else begin
            if (m_c[3])      m_d = 4'b1000;
            else if (m_c[2]) m_d = 4'b0100;
            else if (m_c[1]) m_d = 4'b0010;
            else             m_d = 4'b0001;
         end
      end
   end

   // Result register and strobe.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= cmd.rsp_load;
      if (cmd.rsp_load) begin
         rsp_id_error      <= id_err;
         rsp_deliver_local <= !id_err && (cur_ff == dst_ff);
         rsp_port_mask     <= (id_err || cur_ff == dst_ff) ? 4'b0000 : m_d;
      end
   end

   always_comb begin
      status.id_err      = id_err;
      status.is_local    = (cur_ff == dst_ff);
      status.table_ready = table_ready_ff;
      status.clr_last    = (clr_cnt_ff == n_eff - NW'(1));
      status.mod_last    = (bit_ff == 4'd0);
      status.q_empty     = (head_ff == tail_ff);
      status.k_last      = (k_ff == 2'd3);
   end

endmodule
`default_nettype wire

### hdl/circulant_shortest_path_router_core.sv
// Top level of the circulant shortest-path router: controller plus datapath.
//
//   Channel   Direction  Handshake             Payload
//   request   in         start & !busy         req_current_node, req_destination_node,
//                                              req_arrival_port
//   response  out        rsp_valid (1 cycle)   rsp_port_mask, rsp_deliver_local,
//                                              rsp_id_error
//   config    in         csr_valid & csr_ready csr_index, csr_data
//
// A request with a ready table steps from CHECK through a read and an
// accumulate state for each of the four links to RESP, which loads the
// response registers and strobe; the four table lookups share one read
// port of the distance table. A bad id or local delivery goes from CHECK
// straight to RESP. After reset or any configuration transfer, the first
// routed request also rebuilds the table: it clears the n visited marks,
// finds s mod n and walks breadth-first (n is the effective node count).
// Reset is synchronous and active high and leaves the table marked stale.
// The receiver cannot stall responses; csr_ready is always high and writes
// are expected only while busy is low.
`timescale 1ns / 1ps
`default_nettype none
module circulant_shortest_path_router_core #(
   parameter int MAX_NODES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [csp_pkg::ID_W-1:0]          req_current_node,
   input  wire logic [csp_pkg::ID_W-1:0]          req_destination_node,
   input  wire logic [csp_pkg::PORT_W-1:0]        req_arrival_port,
   output logic                                   rsp_valid,
   output logic [csp_pkg::MASK_W-1:0]             rsp_port_mask,
   output logic                                   rsp_deliver_local,
   output logic                                   rsp_id_error,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [csp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [csp_pkg::CSR_DATA_W-1:0]    csr_data
);

   csp_pkg::cmd_type    cmd;
   csp_pkg::status_type status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   csp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   csp_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_current_node     (req_current_node),
      .req_destination_node (req_destination_node),
      .req_arrival_port     (req_arrival_port),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_port_mask        (rsp_port_mask),
      .rsp_deliver_local    (rsp_deliver_local),
      .rsp_id_error         (rsp_id_error)
   );

   // A response is a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not start work");

   // An id error gives no ports and no local delivery.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_id_error) |-> (rsp_port_mask == 4'b0000 && !rsp_deliver_local))
      else $error("id error response carries ports or local delivery");

   // Local delivery never names a link.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_deliver_local) |-> (rsp_port_mask == 4'b0000))
      else $error("local delivery response carries ports");

endmodule
`default_nettype wire
